FILE: rtl/thi_pkg.sv
// Shared constants for the trilinear hex interpolator: default widths,
// pipeline stage numbering and configuration register indexes.
// No dependencies.
`default_nettype none

package thi_pkg;

  localparam int COORD_WIDTH_DEF = 21;
  localparam int FRAC_BITS_DEF   = 15;

  localparam int IN_W        = 16;  // width of u, v, w on the input word
  localparam int CFG_DATA_W  = 63;
  localparam int CFG_IDX_W   = 4;
  localparam int NUM_CORNERS = 8;

  // pipeline stages, one register rank each
  localparam int ST_UV      = 0;  // clamp, (1-u)/u times (1-v)/v
  localparam int ST_WT      = 1;  // times (1-w)/w: eight corner weights
  localparam int ST_MUL     = 2;  // corner times weight, split in two halves
  localparam int ST_ADD1    = 3;  // 8 -> 4
  localparam int ST_ADD2    = 4;  // 4 -> 2
  localparam int ST_ADD3    = 5;  // 2 -> 1
  localparam int ST_OUT     = 6;  // merge halves, round, saturate
  localparam int NUM_STAGES = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_0 = 4'd0,
    REG_CORNER_1 = 4'd1,
    REG_CORNER_2 = 4'd2,
    REG_CORNER_3 = 4'd3,
    REG_CORNER_4 = 4'd4,
    REG_CORNER_5 = 4'd5,
    REG_CORNER_6 = 4'd6,
    REG_CORNER_7 = 4'd7
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: rtl/thi_intf.sv
// Channel interfaces of the trilinear hex interpolator: point input,
// interpolated point output and configuration write. Uses thi_pkg.
`default_nettype none

interface thi_pnt_in_if;
  logic                      valid;
  logic                      ready;
  logic [thi_pkg::IN_W-1:0]  u_coord;
  logic [thi_pkg::IN_W-1:0]  v_coord;
  logic [thi_pkg::IN_W-1:0]  w_coord;

  modport source (output valid, output u_coord, output v_coord, output w_coord,
                  input ready);
  modport sink   (input valid, input u_coord, input v_coord, input w_coord,
                  output ready);
endinterface

interface thi_pnt_out_if #(
  parameter int CW = thi_pkg::COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] x_out;
  logic signed [CW-1:0] y_out;
  logic signed [CW-1:0] z_out;

  modport source (output valid, output x_out, output y_out, output z_out,
                  input ready);
  modport sink   (input valid, input x_out, input y_out, input z_out,
                  output ready);
endinterface

interface thi_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [thi_pkg::CFG_IDX_W-1:0]   index;
  logic [thi_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/thi_weight.sv
// Corner weight stages of the interpolator: clamps u, v, w and forms the
// eight trilinear weights over two register ranks. Uses thi_pkg.
`default_nettype none

module thi_weight #(
  parameter int FRAC_BITS = thi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic [thi_pkg::NUM_STAGES-1:0]    en_i,
  input  logic [thi_pkg::IN_W-1:0]          u_i,
  input  logic [thi_pkg::IN_W-1:0]          v_i,
  input  logic [thi_pkg::IN_W-1:0]          w_i,
  output logic [3*FRAC_BITS:0]              wt_o [thi_pkg::NUM_CORNERS]
);
  import thi_pkg::*;

  localparam int FW  = FRAC_BITS + 1;
  localparam int UVW = 2 * FRAC_BITS + 1;
  localparam int WW  = 3 * FRAC_BITS + 1;
  localparam int PW  = 2 * FW;
  localparam int PWW = UVW + FW;

  localparam logic [IN_W:0] ONE_EXT = (IN_W + 1)'(1) << FRAC_BITS;
  localparam logic [FW-1:0] ONE_F   = FW'(1) << FRAC_BITS;

  function automatic logic [FW-1:0] clamp_one(input logic [IN_W-1:0] c);
    logic [IN_W:0] ce;
    ce = {1'b0, c};
    if (ce > ONE_EXT) begin
      ce = ONE_EXT;
    end
    return ce[FW-1:0];
  endfunction

  logic [FW-1:0]        fu [2];
  logic [FW-1:0]        fv [2];
  logic [FW-1:0]        fw_d [2];
  logic [PW-1:0]        prod_uv [4];
  logic [UVW-1:0]       uv_q [4];
  logic [FW-1:0]        fw_q [2];
  logic [PWW-1:0]       prod_wt [NUM_CORNERS];
  logic [WW-1:0]        wt_q [NUM_CORNERS];

  always_comb begin
    fu[1]   = clamp_one(u_i);
    fu[0]   = ONE_F - fu[1];
    fv[1]   = clamp_one(v_i);
    fv[0]   = ONE_F - fv[1];
    fw_d[1] = clamp_one(w_i);
    fw_d[0] = ONE_F - fw_d[1];
    // hex vertex order around the bottom face
    prod_uv[0] = PW'(fu[0]) * PW'(fv[0]);
    prod_uv[1] = PW'(fu[1]) * PW'(fv[0]);
    prod_uv[2] = PW'(fu[1]) * PW'(fv[1]);
    prod_uv[3] = PW'(fu[0]) * PW'(fv[1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_UV]) begin
      for (int m = 0; m < 4; m++) begin
        uv_q[m] <= prod_uv[m][UVW-1:0];
      end
      fw_q <= fw_d;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      prod_wt[k] = PWW'(uv_q[k % 4]) * PWW'(fw_q[k / 4]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_WT]) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        wt_q[k] <= prod_wt[k][WW-1:0];
      end
    end
  end

  assign wt_o = wt_q;

endmodule

`default_nettype wire

FILE: rtl/thi_blend.sv
// One output coordinate of the interpolator: corner times weight, adder
// tree, round to nearest and saturate, over five register ranks. Uses thi_pkg.
`default_nettype none

module thi_blend #(
  parameter int COORD_WIDTH = thi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = thi_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic [thi_pkg::NUM_STAGES-1:0]  en_i,
  input  logic [3*FRAC_BITS:0]            wt_i  [thi_pkg::NUM_CORNERS],
  input  logic [COORD_WIDTH-1:0]          crn_i [thi_pkg::NUM_CORNERS],
  output logic [COORD_WIDTH-1:0]          res_o
);
  import thi_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int WW     = 3 * FRAC_BITS + 1;
  localparam int WSHIFT = 3 * FRAC_BITS;
  localparam int WLO    = (WW + 1) / 2;
  localparam int WHI    = WW - WLO;
  localparam int PLW    = CW + WLO;
  localparam int PHW    = CW + WHI;
  localparam int TW     = CW + WW + 4;
  localparam int RW     = TW - WSHIFT;

  localparam logic [CW-1:0] SIGN = CW'(1) << (CW - 1);
  localparam logic [TW-1:0] HALF = TW'(1) << (WSHIFT - 1);

  logic [CW-1:0]  cb [NUM_CORNERS];
  logic [PLW-1:0] plo_q [NUM_CORNERS];
  logic [PHW-1:0] phi_q [NUM_CORNERS];
  logic [PLW:0]   l1lo_q [4];
  logic [PHW:0]   l1hi_q [4];
  logic [PLW+1:0] l2lo_q [2];
  logic [PHW+1:0] l2hi_q [2];
  logic [PLW+2:0] l3lo_q;
  logic [PHW+2:0] l3hi_q;
  logic [TW-1:0]  tot;
  logic [RW-1:0]  rnd;
  logic [CW-1:0]  sat;
  logic [CW-1:0]  res_q;

  // offset binary keeps every product unsigned
  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      cb[k] = crn_i[k] ^ SIGN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_MUL]) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        plo_q[k] <= PLW'(cb[k]) * PLW'(wt_i[k][WLO-1:0]);
        phi_q[k] <= PHW'(cb[k]) * PHW'(wt_i[k][WW-1:WLO]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_ADD1]) begin
      for (int j = 0; j < 4; j++) begin
        l1lo_q[j] <= {1'b0, plo_q[2*j]} + {1'b0, plo_q[2*j+1]};
        l1hi_q[j] <= {1'b0, phi_q[2*j]} + {1'b0, phi_q[2*j+1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_ADD2]) begin
      for (int j = 0; j < 2; j++) begin
        l2lo_q[j] <= {1'b0, l1lo_q[2*j]} + {1'b0, l1lo_q[2*j+1]};
        l2hi_q[j] <= {1'b0, l1hi_q[2*j]} + {1'b0, l1hi_q[2*j+1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_ADD3]) begin
      l3lo_q <= {1'b0, l2lo_q[0]} + {1'b0, l2lo_q[1]};
      l3hi_q <= {1'b0, l2hi_q[0]} + {1'b0, l2hi_q[1]};
    end
  end

  // merge the halves, add half an lsb, drop the weight fraction
  always_comb begin
    tot = TW'({l3hi_q, {WLO{1'b0}}}) + TW'(l3lo_q) + HALF;
    rnd = tot[TW-1:WSHIFT];
    if (|rnd[RW-1:CW]) begin
      sat = {CW{1'b1}};
    end else begin
      sat = rnd[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_OUT]) begin
      res_q <= sat ^ SIGN;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/trilinear_hex_interpolator.sv
// Trilinear interpolation inside a hexahedron given by eight corners.
// Top level: corner registers, pipeline valid/ready control, datapath.
// Uses thi_pkg, thi_intf, thi_weight and thi_blend.
//
// Channels: pnt_i takes one (u,v,w) word, each Q1.(FRAC_BITS) unsigned,
// values above one are clamped to one. pnt_o gives the interpolated
// (x,y,z), rounded to nearest and saturated to COORD_WIDTH bits signed.
// cfg_i writes corner k at index k (x, y, z packed from bit 0); indexes
// above seven are ignored. cfg_i is always ready and should only be used
// while no point is in flight.
// An accepted word passes the ranks in order: two ranks form the corner
// weights, one multiplies corners by weights, three reduce the eight
// products, one rounds into the output register, which drives pnt_o.valid.
// Throughput is one point per cycle unless pnt_o stalls. Each rank has its
// own valid bit and loads when it is empty or the rank after it moves, so
// a stalled receiver fills the pipeline bubbles first and then drops
// pnt_i.ready; nothing is lost or repeated. Reset clears the valid bits and
// all corners to zero.
`default_nettype none

module trilinear_hex_interpolator #(
  parameter int COORD_WIDTH = thi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = thi_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  thi_pnt_in_if.sink     pnt_i,
  thi_pnt_out_if.source  pnt_o,
  thi_cfg_if.sink        cfg_i
);
  import thi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int WW = 3 * FRAC_BITS + 1;

  logic [3*CW-1:0]       corner_q [NUM_CORNERS];
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] vld_d;
  logic [NUM_STAGES-1:0] rdy;
  logic [WW-1:0]         wt [NUM_CORNERS];
  logic [CW-1:0]         crn [3][NUM_CORNERS];
  logic [CW-1:0]         res [3];

  // corner registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        corner_q[k] <= '0;
      end
    end else if (cfg_i.valid && (cfg_i.index <= REG_CORNER_7)) begin
      corner_q[cfg_i.index[2:0]] <= cfg_i.data[3*CW-1:0];
    end
  end

  always_comb begin
    for (int f = 0; f < 3; f++) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        crn[f][k] = corner_q[k][f*CW +: CW];
      end
    end
  end

  // a rank loads when it is empty or its successor loads
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || pnt_o.ready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
    vld_d[0] = pnt_i.valid;
    for (int s = 1; s < NUM_STAGES; s++) begin
      vld_d[s] = vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_d[s];
        end
      end
    end
  end

  assign pnt_i.ready = rdy[0];
  assign pnt_o.valid = vld_q[NUM_STAGES-1];

  thi_weight #(
    .FRAC_BITS (FRAC_BITS)
  ) u_weight (
    .clk_i (clk_i),
    .en_i  (rdy),
    .u_i   (pnt_i.u_coord),
    .v_i   (pnt_i.v_coord),
    .w_i   (pnt_i.w_coord),
    .wt_o  (wt)
  );

  for (genvar f = 0; f < 3; f++) begin : g_axis
    thi_blend #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_blend (
      .clk_i (clk_i),
      .en_i  (rdy),
      .wt_i  (wt),
      .crn_i (crn[f]),
      .res_o (res[f])
    );
  end

  assign pnt_o.x_out = res[0];
  assign pnt_o.y_out = res[1];
  assign pnt_o.z_out = res[2];

endmodule

`default_nettype wire

FILE: rtl/thi_checker.sv
// Port-level checks for the trilinear hex interpolator, bound to the top
// level. Sees only the channel handshakes and the output word.
`default_nettype none

module thi_checker #(
  parameter int CW = thi_pkg::COORD_WIDTH_DEF
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_i,
  input wire logic          out_valid_i,
  input wire logic          out_ready_i,
  input wire logic [CW-1:0] x_i,
  input wire logic [CW-1:0] y_i,
  input wire logic [CW-1:0] z_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(x_i) && $stable(y_i)
      && $stable(z_i))
    else $error("output word changed while stalled");

  // with the receiver taking words, the pipeline never backs up to the input
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled although output is ready");

  // an accepted word reaches the output when the receiver does not stall
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("accepted word did not reach the output in time");

endmodule

bind trilinear_hex_interpolator thi_checker #(
  .CW (COORD_WIDTH)
) u_thi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pnt_i.valid),
  .in_ready_i  (pnt_i.ready),
  .out_valid_i (pnt_o.valid),
  .out_ready_i (pnt_o.ready),
  .x_i         (pnt_o.x_out),
  .y_i         (pnt_o.y_out),
  .z_i         (pnt_o.z_out)
);

`default_nettype wire
